// ===== rtl/core/mcnr_pkg.sv =====
package mcnr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DATA_W  = 7;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned HZ_W    = 14;
    localparam int unsigned CNT_W   = 2;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_LISTEN_CHANNEL = 3'd0;

    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CTRL     = 4'hB;

    localparam logic [KIND_W-1:0] EV_START   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_CTRL    = 2'd2;
    localparam logic [KIND_W-1:0] EV_UNUSED  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_STATUS = 2'd1;
    localparam logic [CNT_W-1:0] CNT_DATA1  = 2'd2;
    localparam logic [CNT_W-1:0] CNT_FULL   = 2'd3;

    localparam logic [HZ_W-1:0] NOTE_HZ [128] = '{
        14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
        14'd12, 14'd13, 14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
        14'd20, 14'd21, 14'd23, 14'd24, 14'd25, 14'd27, 14'd29, 14'd30,
        14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
        14'd51, 14'd54, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
        14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd109, 14'd116, 14'd123,
        14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
        14'd207, 14'd219, 14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311,
        14'd329, 14'd349, 14'd369, 14'd391, 14'd415, 14'd440, 14'd466, 14'd493,
        14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
        14'd830, 14'd880, 14'd932, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244,
        14'd1318, 14'd1396, 14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
        14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959, 14'd3135,
        14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978,
        14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
        14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839, 14'd12543
    };

endpackage

// ===== rtl/core/midi_channel_note_receiver.sv =====
// Channel  | Direction | Ports                                   | Moves
// s_       | in        | s_valid, s_ready, s_rx_byte             | one MIDI byte per word
// m_       | out       | m_valid, m_ready, m_event_kind, ...     | one event per word
// APB      | config    | psel, penable, pwrite, paddr, pwdata    | listen_channel at 0x0
//
// One byte per cycle while s_ready is high: an input register, then the parser
// state and the result register, which take each byte from the input register.
// aresetn is synchronous: it clears capture state, valids and listen_channel.
// s_ready drops only while the input register holds a byte and the result
// register holds an event that m_ready has not taken.
module midi_channel_note_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mcnr_pkg::BYTE_W-1:0]       s_rx_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mcnr_pkg::KIND_W-1:0]       m_event_kind,
    output logic [mcnr_pkg::DATA_W-1:0]       m_note_or_number,
    output logic [mcnr_pkg::DATA_W-1:0]       m_level,
    output logic [mcnr_pkg::HZ_W-1:0]         m_frequency_hz,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mcnr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mcnr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mcnr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [mcnr_pkg::CHAN_W-1:0]  listen_channel_reg;

    logic                         in_vld_reg;
    logic [mcnr_pkg::BYTE_W-1:0]  in_byte_reg;

    logic                         capturing_reg, capturing_next;
    logic [mcnr_pkg::CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [mcnr_pkg::BYTE_W-1:0]  status_byte_reg, status_byte_next;
    logic [mcnr_pkg::DATA_W-1:0]  first_data_reg, first_data_next;
    logic [mcnr_pkg::DATA_W-1:0]  last_note_reg, last_note_next;

    logic                         out_vld_reg, out_vld_next;
    logic [mcnr_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [mcnr_pkg::DATA_W-1:0]  out_note_reg, out_note_next;
    logic [mcnr_pkg::DATA_W-1:0]  out_level_reg, out_level_next;
    logic [mcnr_pkg::HZ_W-1:0]    out_hz_reg, out_hz_next;

    logic                         advance;
    logic                         emit;
    logic [mcnr_pkg::DATA_W-1:0]  data_in;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == mcnr_pkg::ADDR_LISTEN_CHANNEL)
                  ? {{(mcnr_pkg::APB_DATA_W-mcnr_pkg::CHAN_W){1'b0}}, listen_channel_reg}
                  : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_channel_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == mcnr_pkg::ADDR_LISTEN_CHANNEL) begin
            listen_channel_reg <= pwdata[mcnr_pkg::CHAN_W-1:0];
        end
    end

    // handshake
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // parser
    assign data_in = in_byte_reg[mcnr_pkg::DATA_W-1:0];

    always_comb begin
        capturing_next   = capturing_reg;
        byte_count_next  = byte_count_reg;
        status_byte_next = status_byte_reg;
        first_data_next  = first_data_reg;
        last_note_next   = last_note_reg;
        emit             = 1'b0;
        out_kind_next    = mcnr_pkg::EV_START;
        out_note_next    = first_data_reg;
        out_level_next   = data_in;
        out_hz_next      = '0;

        if (in_byte_reg[mcnr_pkg::BYTE_W-1]) begin
            if (in_byte_reg[mcnr_pkg::CHAN_W-1:0] == listen_channel_reg) begin
                capturing_next   = 1'b1;
                status_byte_next = in_byte_reg;
                byte_count_next  = mcnr_pkg::CNT_STATUS;
            end else begin
                capturing_next = 1'b0;
            end
        end else if (capturing_reg && byte_count_reg != mcnr_pkg::CNT_FULL) begin
            if (byte_count_reg == mcnr_pkg::CNT_STATUS) begin
                first_data_next = data_in;
                byte_count_next = mcnr_pkg::CNT_DATA1;
            end else begin
                byte_count_next = mcnr_pkg::CNT_FULL;
                case (status_byte_reg[mcnr_pkg::BYTE_W-1:mcnr_pkg::CHAN_W])
                    mcnr_pkg::STATUS_NOTE_ON: begin
                        last_note_next = first_data_reg;
                        emit           = 1'b1;
                        out_kind_next  = mcnr_pkg::EV_START;
                        out_hz_next    = mcnr_pkg::NOTE_HZ[first_data_reg];
                    end
                    mcnr_pkg::STATUS_NOTE_OFF: begin
                        emit          = (last_note_reg == first_data_reg);
                        out_kind_next = mcnr_pkg::EV_RELEASE;
                    end
                    mcnr_pkg::STATUS_CTRL: begin
                        emit          = 1'b1;
                        out_kind_next = mcnr_pkg::EV_CTRL;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (advance) begin
            out_vld_next = emit;
        end else begin
            out_vld_next = out_vld_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg   <= 1'b0;
            byte_count_reg  <= '0;
            status_byte_reg <= '0;
            first_data_reg  <= '0;
            last_note_reg   <= '0;
            out_vld_reg     <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (advance) begin
                capturing_reg   <= capturing_next;
                byte_count_reg  <= byte_count_next;
                status_byte_reg <= status_byte_next;
                first_data_reg  <= first_data_next;
                last_note_reg   <= last_note_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_kind_reg  <= out_kind_next;
            out_note_reg  <= out_note_next;
            out_level_reg <= out_level_next;
            out_hz_reg    <= out_hz_next;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_event_kind     = out_kind_reg;
    assign m_note_or_number = out_note_reg;
    assign m_level          = out_level_reg;
    assign m_frequency_hz   = out_hz_reg;

    // checks
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && out_vld_reg && !m_ready)
        else $error("input stalled without a blocked event");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_kind != mcnr_pkg::EV_UNUSED)
        else $error("illegal event kind");

    a_hz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != mcnr_pkg::EV_START |-> m_frequency_hz == '0)
        else $error("frequency on non-start event");

    a_hz_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == mcnr_pkg::EV_START
        |-> m_frequency_hz == mcnr_pkg::NOTE_HZ[m_note_or_number])
        else $error("start frequency does not match note");

    a_release_note: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit && out_kind_next == mcnr_pkg::EV_RELEASE
        |-> first_data_reg == last_note_reg)
        else $error("release for a note that is not held");

endmodule
